FILE: hw/rtl/grid_best_feature_table_unit_assert.svh
// Assertion macros for the grid feature table RTL.
`ifndef GRID_BEST_FEATURE_TABLE_UNIT_ASSERT_SVH
`define GRID_BEST_FEATURE_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define GBFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBFT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define GBFT_ASSERT(label, clk, rst, prop, msg)
`define GBFT_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: hw/rtl/gbft_pkg.sv
`default_nettype none
package gbft_pkg;

   localparam int COORD_PORT_BITS    = 12;
   localparam int STRENGTH_PORT_BITS = 16;
   localparam int INDEX_PORT_BITS    = 10;
   localparam int CFG_BITS           = 11;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int DIV_BITS           = 12;
   localparam int DIV_COUNT_BITS     = 4;
   localparam int COARSE_BITS        = 24;
   localparam int PRODUCT_BITS       = 35;
   localparam int CELL_SUM_BITS      = 36;
   localparam int REQ_DATA_BITS      = 56;
   localparam int RSP_DATA_BITS      = 56;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_OFFER     = 2'd1,
      OP_PROPAGATE = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COARSE_WIDTH  = 3'd0,
      REG_COARSE_HEIGHT = 3'd1,
      REG_FINE_WIDTH    = 3'd2,
      REG_FINE_HEIGHT   = 3'd3,
      REG_COARSE_COLS   = 3'd4,
      REG_COARSE_COUNT  = 3'd5,
      REG_FINE_PER      = 3'd6,
      REG_FINE_COLS     = 3'd7
   } reg_index_type;

   localparam logic [CFG_BITS-1:0] RST_COARSE_WIDTH  = 11'd64;
   localparam logic [CFG_BITS-1:0] RST_COARSE_HEIGHT = 11'd64;
   localparam logic [CFG_BITS-1:0] RST_FINE_WIDTH    = 11'd16;
   localparam logic [CFG_BITS-1:0] RST_FINE_HEIGHT   = 11'd16;
   localparam logic [CFG_BITS-1:0] RST_COARSE_COLS   = 11'd8;
   localparam logic [CFG_BITS-1:0] RST_COARSE_COUNT  = 11'd64;
   localparam logic [CFG_BITS-1:0] RST_FINE_PER      = 11'd16;
   localparam logic [CFG_BITS-1:0] RST_FINE_COLS     = 11'd4;

   typedef struct packed {
      logic [INDEX_PORT_BITS-1:0]    read_index;
      logic [STRENGTH_PORT_BITS-1:0] strength;
      logic [COORD_PORT_BITS-1:0]    point_y;
      logic [COORD_PORT_BITS-1:0]    point_x;
   } req_fields_type;

   localparam int REQ_FIELD_BITS = $bits(req_fields_type);

   typedef struct packed {
      logic [STRENGTH_PORT_BITS-1:0] kept_strength;
      logic [COORD_PORT_BITS-1:0]    kept_y;
      logic [COORD_PORT_BITS-1:0]    kept_x;
      logic                          has_feature;
      logic                          cell_active;
      logic                          stored;
      logic [INDEX_PORT_BITS-1:0]    cell_number;
      logic                          in_bounds;
   } rsp_fields_type;

   typedef struct packed {
      logic valid;
      logic enabled;
   } cell_flags_type;

   localparam cell_flags_type FLAGS_CLEARED = '{valid: 1'b0, enabled: 1'b1};

   // A block size of zero divides as one.
   function automatic logic [DIV_BITS-1:0] divisor_of(input logic [CFG_BITS-1:0] value);
      return (value == '0) ? DIV_BITS'(1) : DIV_BITS'(value);
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/grid_best_feature_table_unit.sv
`default_nettype none
// Strongest-feature-per-cell table over a two-level image grid.
// The request channel (req_) carries one operation per request: clear the table,
// offer a feature, mark a propagated point's cell inactive, or read one cell.
// Every request returns exactly one response on the rsp_ channel.
// The csr_ channel writes the eight grid registers; write it only while idle.
// Offer and propagate pass from acceptance to rsp_tvalid through four 12-step
// divisions on one shared restoring divider, three passes through one shared
// multiplier, a bounds check and, if in bounds, a cell memory read-modify-write.
// A clear sweeps the flag memory, one cell per cycle, and then responds.
// After reset the same sweep runs over every cell with req_tready low;
// csr writes are taken meanwhile.
// The response sits in an output register: a new request is taken while it
// waits, but the next result waits until rsp_tready has taken the previous one.
// Only one request is worked on at a time; the next one can be taken in the same
// cycle that rsp_tvalid rises.
`include "grid_best_feature_table_unit_assert.svh"
module grid_best_feature_table_unit
   import gbft_pkg::*;
#(
   parameter int FINE_CELLS    = 1024,
   parameter int COORD_BITS    = 12,
   parameter int STRENGTH_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // point_x[11:0], point_y[23:12], strength[39:24], read_index[49:40], zero above
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // op[1:0]
   input  wire logic [1:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // in_bounds[0], cell_number[10:1], stored[11], cell_active[12], has_feature[13],
   // kept_x[25:14], kept_y[37:26], kept_strength[53:38], zero above
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data
);

   localparam int XW = (COORD_BITS < COORD_PORT_BITS) ? COORD_BITS : COORD_PORT_BITS;
   localparam int SW = (STRENGTH_BITS < STRENGTH_PORT_BITS) ? STRENGTH_BITS
                                                            : STRENGTH_PORT_BITS;
   localparam int FW = 2 * XW + SW;
   localparam int CB = (FINE_CELLS > 1) ? $clog2(FINE_CELLS) : 1;
   localparam logic [CB-1:0] LAST_CELL = CB'(FINE_CELLS - 1);
   localparam logic [CELL_SUM_BITS-1:0] CELL_LIMIT = CELL_SUM_BITS'(FINE_CELLS);
   localparam logic [DIV_COUNT_BITS-1:0] DIV_LAST = DIV_COUNT_BITS'(DIV_BITS - 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DIV, S_MUL, S_CHECK, S_READ, S_RMW, S_ZERO, S_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      DIV_X_COARSE, DIV_X_FINE, DIV_Y_COARSE, DIV_Y_FINE
   } div_phase_type;

   typedef enum logic [1:0] {
      MUL_COARSE, MUL_BASE, MUL_FINE
   } mul_phase_type;

   state_type      state_ff, state_in;
   div_phase_type  div_sel_ff, div_sel_in;
   mul_phase_type  mul_sel_ff, mul_sel_in;
   logic [DIV_COUNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic [CB-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_ff, rsp_in;

   logic [CFG_BITS-1:0] cbw_ff, cbw_in, cbh_ff, cbh_in, fbw_ff, fbw_in, fbh_ff, fbh_in;
   logic [CFG_BITS-1:0] ccol_ff, ccol_in, ccnt_ff, ccnt_in, fper_ff, fper_in;
   logic [CFG_BITS-1:0] fcol_ff, fcol_in;

   op_type              op_ff, op_in;
   logic [XW-1:0]       x_ff, x_in, y_ff, y_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [DIV_BITS-1:0] qx_ff, qx_in, fx_ff, fx_in, qy_ff, qy_in;
   logic [COARSE_BITS-1:0]   coarse_ff, coarse_in;
   logic [CELL_SUM_BITS-1:0] cell_ff, cell_in;

   req_fields_type req_fields;
   logic [DIV_BITS-1:0] divisor, trial, rem_step, quo_step;
   logic                fits;
   logic [COARSE_BITS-1:0]  mul_a;
   logic [CFG_BITS-1:0]     mul_b;
   logic [PRODUCT_BITS-1:0] product;

   cell_flags_type flag_mem [FINE_CELLS];
   logic [FW-1:0]  feat_mem [FINE_CELLS];
   cell_flags_type flag_rd_ff, new_flags, flag_wdata;
   logic [FW-1:0]  feat_rd_ff, new_feat;
   logic [CB-1:0]  mem_addr, flag_waddr;
   logic           flag_we, feat_we, take, rsp_free, rmw_go, sweeping;

   assign req_fields = req_tdata[REQ_FIELD_BITS-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Shared restoring divider, one quotient bit per cycle.
   always_comb begin
      case (div_sel_ff)
         DIV_X_COARSE: divisor = divisor_of(cbw_ff);
         DIV_X_FINE:   divisor = divisor_of(fbw_ff);
         DIV_Y_COARSE: divisor = divisor_of(cbh_ff);
         default:      divisor = divisor_of(fbh_ff);
      endcase
      trial    = {rem_ff[DIV_BITS-2:0], quo_ff[DIV_BITS-1]};
      fits     = (trial >= divisor);
      rem_step = fits ? (trial - divisor) : trial;
      quo_step = {quo_ff[DIV_BITS-2:0], fits};
   end

   // Shared multiplier.
   always_comb begin
      case (mul_sel_ff)
         MUL_COARSE: begin
            mul_a = COARSE_BITS'(qy_ff);
            mul_b = ccol_ff;
         end
         MUL_BASE: begin
            mul_a = coarse_ff;
            mul_b = fper_ff;
         end
         default: begin
            mul_a = COARSE_BITS'(quo_ff);
            mul_b = fcol_ff;
         end
      endcase
      product = PRODUCT_BITS'(mul_a) * PRODUCT_BITS'(mul_b);
   end

   // Cell update from the registered memory read.
   always_comb begin
      new_flags = flag_rd_ff;
      take      = 1'b0;
      case (op_ff)
         OP_OFFER: begin
            take = flag_rd_ff.enabled &&
                   (!flag_rd_ff.valid || (feat_rd_ff[SW-1:0] < s_ff));
            if (take) begin
               new_flags.valid = 1'b1;
            end
         end
         OP_PROPAGATE: begin
            new_flags.enabled = 1'b0;
         end
         default: begin
         end
      endcase
      new_feat = take ? {x_ff, y_ff, s_ff} : feat_rd_ff;
   end

   assign sweeping   = (state_ff == S_INIT) || (state_ff == S_CLEAR);
   assign rmw_go     = (state_ff == S_RMW) && rsp_free;
   assign mem_addr   = cell_ff[CB-1:0];
   assign flag_waddr = sweeping ? sweep_cnt_ff : mem_addr;
   assign flag_wdata = sweeping ? FLAGS_CLEARED : new_flags;
   assign flag_we    = sweeping || rmw_go;
   assign feat_we    = rmw_go && take;

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_waddr] <= flag_wdata;
      end
      flag_rd_ff <= flag_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[mem_addr] <= new_feat;
      end
      feat_rd_ff <= feat_mem[mem_addr];
   end

   always_comb begin
      state_in     = state_ff;
      div_sel_in   = div_sel_ff;
      mul_sel_in   = mul_sel_ff;
      div_cnt_in   = div_cnt_ff;
      sweep_cnt_in = sweep_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      s_in         = s_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      qx_in        = qx_ff;
      fx_in        = fx_ff;
      qy_in        = qy_ff;
      coarse_in    = coarse_ff;
      cell_in      = cell_ff;

      cbw_in  = cbw_ff;
      cbh_in  = cbh_ff;
      fbw_in  = fbw_ff;
      fbh_in  = fbh_ff;
      ccol_in = ccol_ff;
      ccnt_in = ccnt_ff;
      fper_in = fper_ff;
      fcol_in = fcol_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_COARSE_WIDTH:  cbw_in  = csr_data;
            REG_COARSE_HEIGHT: cbh_in  = csr_data;
            REG_FINE_WIDTH:    fbw_in  = csr_data;
            REG_FINE_HEIGHT:   fbh_in  = csr_data;
            REG_COARSE_COLS:   ccol_in = csr_data;
            REG_COARSE_COUNT:  ccnt_in = csr_data;
            REG_FINE_PER:      fper_in = csr_data;
            REG_FINE_COLS:     fcol_in = csr_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_INIT, S_CLEAR: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == LAST_CELL) begin
               sweep_cnt_in = '0;
               state_in     = (state_ff == S_CLEAR) ? S_ZERO : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in  = op_type'(req_tuser);
               x_in   = req_fields.point_x[XW-1:0];
               y_in   = req_fields.point_y[XW-1:0];
               s_in   = req_fields.strength[SW-1:0];
               quo_in = DIV_BITS'(req_fields.point_x[XW-1:0]);
               rem_in = '0;
               div_cnt_in = '0;
               div_sel_in = DIV_X_COARSE;
               case (op_type'(req_tuser))
                  OP_CLEAR: begin
                     sweep_cnt_in = '0;
                     state_in     = S_CLEAR;
                  end
                  OP_READ: begin
                     cell_in = CELL_SUM_BITS'(req_fields.read_index);
                     if (CELL_SUM_BITS'(req_fields.read_index) < CELL_LIMIT) begin
                        state_in = S_READ;
                     end else begin
                        state_in = S_ZERO;
                     end
                  end
                  default: state_in = S_DIV;
               endcase
            end
         end
         S_DIV: begin
            quo_in     = quo_step;
            rem_in     = rem_step;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               div_cnt_in = '0;
               rem_in     = '0;
               case (div_sel_ff)
                  DIV_X_COARSE: begin
                     qx_in      = quo_step;
                     quo_in     = rem_step;
                     div_sel_in = DIV_X_FINE;
                  end
                  DIV_X_FINE: begin
                     fx_in      = quo_step;
                     quo_in     = DIV_BITS'(y_ff);
                     div_sel_in = DIV_Y_COARSE;
                  end
                  DIV_Y_COARSE: begin
                     qy_in      = quo_step;
                     quo_in     = rem_step;
                     div_sel_in = DIV_Y_FINE;
                  end
                  default: begin
                     mul_sel_in = MUL_COARSE;
                     state_in   = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            case (mul_sel_ff)
               MUL_COARSE: begin
                  coarse_in  = COARSE_BITS'(product + PRODUCT_BITS'(qx_ff));
                  mul_sel_in = MUL_BASE;
               end
               MUL_BASE: begin
                  cell_in    = CELL_SUM_BITS'(product);
                  mul_sel_in = MUL_FINE;
               end
               default: begin
                  cell_in  = cell_ff + CELL_SUM_BITS'(product) + CELL_SUM_BITS'(fx_ff);
                  state_in = S_CHECK;
               end
            endcase
         end
         S_CHECK: begin
            if ((coarse_ff >= COARSE_BITS'(ccnt_ff)) || (cell_ff >= CELL_LIMIT)) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_RMW;
         end
         S_RMW: begin
            if (rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.in_bounds   = 1'b1;
               rsp_in.cell_number = cell_ff[INDEX_PORT_BITS-1:0];
               rsp_in.stored      = take;
               rsp_in.cell_active = new_flags.enabled;
               rsp_in.has_feature = new_flags.valid;
               if (new_flags.valid) begin
                  rsp_in.kept_x        = COORD_PORT_BITS'(new_feat[FW-1 -: XW]);
                  rsp_in.kept_y        = COORD_PORT_BITS'(new_feat[SW+XW-1 -: XW]);
                  rsp_in.kept_strength = STRENGTH_PORT_BITS'(new_feat[SW-1:0]);
               end else begin
                  rsp_in.kept_x        = '0;
                  rsp_in.kept_y        = '0;
                  rsp_in.kept_strength = '0;
               end
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         div_sel_ff   <= DIV_X_COARSE;
         mul_sel_ff   <= MUL_COARSE;
         div_cnt_ff   <= '0;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cbw_ff       <= RST_COARSE_WIDTH;
         cbh_ff       <= RST_COARSE_HEIGHT;
         fbw_ff       <= RST_FINE_WIDTH;
         fbh_ff       <= RST_FINE_HEIGHT;
         ccol_ff      <= RST_COARSE_COLS;
         ccnt_ff      <= RST_COARSE_COUNT;
         fper_ff      <= RST_FINE_PER;
         fcol_ff      <= RST_FINE_COLS;
      end else begin
         state_ff     <= state_in;
         div_sel_ff   <= div_sel_in;
         mul_sel_ff   <= mul_sel_in;
         div_cnt_ff   <= div_cnt_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cbw_ff       <= cbw_in;
         cbh_ff       <= cbh_in;
         fbw_ff       <= fbw_in;
         fbh_ff       <= fbh_in;
         ccol_ff      <= ccol_in;
         ccnt_ff      <= ccnt_in;
         fper_ff      <= fper_in;
         fcol_ff      <= fcol_in;
      end
      rsp_ff    <= rsp_in;
      op_ff     <= op_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      s_ff      <= s_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      qx_ff     <= qx_in;
      fx_ff     <= fx_in;
      qy_ff     <= qy_in;
      coarse_ff <= coarse_in;
      cell_ff   <= cell_in;
   end

   `GBFT_ASSERT(a_sweep_blocks_requests, clock, reset, (sweeping |-> !req_tready), "request accepted during table sweep")
   `GBFT_ASSERT(a_out_of_bounds_zero, clock, reset, ((rsp_valid_ff && !rsp_ff.in_bounds) |-> (rsp_ff == '0)), "out-of-bounds response not all zero")
   `GBFT_ASSERT(a_stored_consistent, clock, reset, ((rsp_valid_ff && rsp_ff.stored) |-> (rsp_ff.has_feature && rsp_ff.cell_active && rsp_ff.in_bounds)), "stored feature without active filled cell")
   `GBFT_ASSERT(a_empty_cell_zero, clock, reset, ((rsp_valid_ff && !rsp_ff.has_feature) |-> ((rsp_ff.kept_x == '0) && (rsp_ff.kept_y == '0) && (rsp_ff.kept_strength == '0))), "empty cell reports feature data")
   `GBFT_ASSERT_NEXT(a_rmw_delivers, clock, reset, rmw_go, rsp_valid_ff, "cell update finished without a response")

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import gbft_pkg::*;

   localparam int          FINE_CELLS      = 1024;
   localparam int          PHASES          = 10;
   localparam int          ITEMS_PER_PHASE = 80;
   localparam int          PRESSURE_AT     = 200;
   localparam int          PRESSURE_HOLD   = 600;
   localparam int          DRAIN_CYCLES    = 100;
   localparam int unsigned CYCLE_LIMIT     = 4000000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic [1:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_data;

   typedef struct {
      op_type         op;
      req_fields_type fields;
      bit             typed;
      rsp_fields_type want;
   } probe_row_type;

   // Shadow copy of the grid registers and of the cell store.
   logic [CFG_BITS-1:0]           grid_reg [8];
   logic [CFG_BITS-1:0]           grid_plan [8];
   logic [COORD_PORT_BITS-1:0]    held_x [FINE_CELLS];
   logic [COORD_PORT_BITS-1:0]    held_y [FINE_CELLS];
   logic [STRENGTH_PORT_BITS-1:0] held_strength [FINE_CELLS];
   bit [FINE_CELLS-1:0]           cell_full;
   bit [FINE_CELLS-1:0]           cell_live;

   rsp_fields_type pending_rsp_q [$];
   req_fields_type point_pool [$];
   int unsigned    failures = 0;
   int unsigned    responses_seen = 0;
   int unsigned    span_x = 4096;
   int unsigned    span_y = 4096;
   bit             sender_quiet = 1'b0;

   grid_best_feature_table_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned divisor(input logic [CFG_BITS-1:0] value);
      return (value == '0) ? 64'd1 : 64'(value);
   endfunction

   function automatic bit locate_fine(input logic [COORD_PORT_BITS-1:0] x,
                                      input logic [COORD_PORT_BITS-1:0] y,
                                      output int unsigned fine_idx);
      longint unsigned px, py, cbw, cbh, fbw, fbh, coarse, sum;
      px = x;
      py = y;
      cbw = divisor(grid_reg[REG_COARSE_WIDTH]);
      cbh = divisor(grid_reg[REG_COARSE_HEIGHT]);
      fbw = divisor(grid_reg[REG_FINE_WIDTH]);
      fbh = divisor(grid_reg[REG_FINE_HEIGHT]);
      coarse = (py / cbh) * 64'(grid_reg[REG_COARSE_COLS]) + px / cbw;
      sum = coarse * 64'(grid_reg[REG_FINE_PER])
          + ((py % cbh) / fbh) * 64'(grid_reg[REG_FINE_COLS]) + (px % cbw) / fbw;
      fine_idx = sum[31:0];
      return (coarse < 64'(grid_reg[REG_COARSE_COUNT])) && (sum < FINE_CELLS);
   endfunction

   function automatic rsp_fields_type cell_report(input int unsigned fine_idx, input bit took);
      rsp_fields_type r;
      r = '0;
      r.in_bounds   = 1'b1;
      r.cell_number = INDEX_PORT_BITS'(fine_idx);
      r.stored      = took;
      r.cell_active = cell_live[fine_idx];
      r.has_feature = cell_full[fine_idx];
      if (cell_full[fine_idx]) begin
         r.kept_x        = held_x[fine_idx];
         r.kept_y        = held_y[fine_idx];
         r.kept_strength = held_strength[fine_idx];
      end
      return r;
   endfunction

   function automatic rsp_fields_type predict_cell_response(input op_type op,
                                                            input req_fields_type f);
      rsp_fields_type r;
      int unsigned    fine_idx;
      bit             take;
      r = '0;
      case (op)
         OP_CLEAR: begin
            cell_full = '0;
            cell_live = '1;
         end
         OP_READ: begin
            r = cell_report(f.read_index, 1'b0);
         end
         OP_OFFER: begin
            if (locate_fine(f.point_x, f.point_y, fine_idx)) begin
               take = cell_live[fine_idx] &&
                      (!cell_full[fine_idx] || held_strength[fine_idx] < f.strength);
               if (take) begin
                  held_x[fine_idx]        = f.point_x;
                  held_y[fine_idx]        = f.point_y;
                  held_strength[fine_idx] = f.strength;
                  cell_full[fine_idx]     = 1'b1;
               end
               r = cell_report(fine_idx, take);
            end
         end
         OP_PROPAGATE: begin
            if (locate_fine(f.point_x, f.point_y, fine_idx)) begin
               cell_live[fine_idx] = 1'b0;
               r = cell_report(fine_idx, 1'b0);
            end
         end
      endcase
      return r;
   endfunction

   function automatic void flag_failure(input string what, input longint unsigned want,
                                        input longint unsigned seen);
      failures++;
      if (failures <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", what, want, seen);
      end
   endfunction

   function automatic void check_response(input rsp_fields_type want, input rsp_fields_type seen);
      if (seen.in_bounds !== want.in_bounds)
         flag_failure("in_bounds", want.in_bounds, seen.in_bounds);
      if (seen.cell_number !== want.cell_number)
         flag_failure("cell_number", want.cell_number, seen.cell_number);
      if (seen.stored !== want.stored)
         flag_failure("stored", want.stored, seen.stored);
      if (seen.cell_active !== want.cell_active)
         flag_failure("cell_active", want.cell_active, seen.cell_active);
      if (seen.has_feature !== want.has_feature)
         flag_failure("has_feature", want.has_feature, seen.has_feature);
      if (seen.kept_x !== want.kept_x)
         flag_failure("kept_x", want.kept_x, seen.kept_x);
      if (seen.kept_y !== want.kept_y)
         flag_failure("kept_y", want.kept_y, seen.kept_y);
      if (seen.kept_strength !== want.kept_strength)
         flag_failure("kept_strength", want.kept_strength, seen.kept_strength);
   endfunction

   function automatic probe_row_type probe_row(
      input op_type op, input int unsigned x, y, s, idx, input bit typed,
      input int unsigned inb, num, st, act, has, kx, ky, ks);
      probe_row_type p;
      p.op                  = op;
      p.fields.point_x      = COORD_PORT_BITS'(x);
      p.fields.point_y      = COORD_PORT_BITS'(y);
      p.fields.strength     = STRENGTH_PORT_BITS'(s);
      p.fields.read_index   = INDEX_PORT_BITS'(idx);
      p.typed               = typed;
      p.want                = '0;
      p.want.in_bounds      = inb[0];
      p.want.cell_number    = INDEX_PORT_BITS'(num);
      p.want.stored         = st[0];
      p.want.cell_active    = act[0];
      p.want.has_feature    = has[0];
      p.want.kept_x         = COORD_PORT_BITS'(kx);
      p.want.kept_y         = COORD_PORT_BITS'(ky);
      p.want.kept_strength  = STRENGTH_PORT_BITS'(ks);
      return p;
   endfunction

   function automatic void set_plan(input int unsigned cw, ch, fw, fh, cols, count, per, fcols);
      grid_plan[REG_COARSE_WIDTH]  = CFG_BITS'(cw);
      grid_plan[REG_COARSE_HEIGHT] = CFG_BITS'(ch);
      grid_plan[REG_FINE_WIDTH]    = CFG_BITS'(fw);
      grid_plan[REG_FINE_HEIGHT]   = CFG_BITS'(fh);
      grid_plan[REG_COARSE_COLS]   = CFG_BITS'(cols);
      grid_plan[REG_COARSE_COUNT]  = CFG_BITS'(count);
      grid_plan[REG_FINE_PER]      = CFG_BITS'(per);
      grid_plan[REG_FINE_COLS]     = CFG_BITS'(fcols);
   endfunction

   // The first phases pin the register extremes; the rest are random nested grids.
   task automatic choose_grid(input int phase);
      int unsigned fw, fh, kw, kh, cols, rows;
      case (phase)
         0: begin
            set_plan(1024, 1024, 1024, 1024, 4, 16, 1, 1);
            span_x = 4096;
            span_y = 4096;
         end
         1: begin
            set_plan(1, 1, 1, 1, 32, 1024, 1, 1);
            span_x = 32;
            span_y = 32;
         end
         2: begin
            set_plan(0, 0, 0, 0, 32, 1024, 1, 0);
            span_x = 32;
            span_y = 32;
         end
         3: begin
            set_plan(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
            span_x = 4096;
            span_y = 4096;
         end
         default: begin
            fw = 1 << $urandom_range(0, 5);
            fh = 1 << $urandom_range(0, 5);
            kw = $urandom_range(1, 4);
            kh = $urandom_range(1, 4);
            cols = $urandom_range(1, 12);
            rows = $urandom_range(1, 12);
            set_plan(fw * kw, fh * kh, fw, fh, cols, cols * rows, kw * kh, kw);
            span_x = (cols * fw * kw > 4096) ? 4096 : cols * fw * kw;
            span_y = (rows * fh * kh > 4096) ? 4096 : rows * fh * kh;
         end
      endcase
   endtask

   task automatic load_grid();
      reg_index_type ri;
      ri = ri.first();
      do begin
         csr_valid <= 1'b1;
         csr_index <= ri;
         csr_data  <= grid_plan[ri];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         grid_reg[ri] = grid_plan[ri];
         @(negedge clock);
         ri = ri.next();
      end while (ri != ri.first());
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input op_type op, input req_fields_type f, input bit typed,
                               input rsp_fields_type want);
      int unsigned    gap;
      rsp_fields_type predicted;
      gap = sender_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_BITS'(f);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_cell_response(op, f);
      if (typed) predicted = want;
      pending_rsp_q = {pending_rsp_q, predicted};
      @(negedge clock);
   endtask

   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Some requests revisit recently offered points so that cells see repeated offers.
   task automatic issue_random_item();
      req_fields_type f;
      req_fields_type prev;
      op_type         op;
      int unsigned    pick;
      int unsigned    fine_idx;
      f.point_x    = COORD_PORT_BITS'($urandom_range(0, 4095));
      f.point_y    = COORD_PORT_BITS'($urandom_range(0, 4095));
      f.strength   = STRENGTH_PORT_BITS'($urandom_range(0, 65535));
      f.read_index = INDEX_PORT_BITS'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         op = OP_CLEAR;
      end else if (pick < 10) begin
         op = op_type'($urandom_range(0, 3));
      end else begin
         if (point_pool.size() > 0 && $urandom_range(0, 1) == 1) begin
            prev = point_pool[$urandom_range(0, point_pool.size() - 1)];
            f.point_x = prev.point_x;
            f.point_y = prev.point_y;
            case ($urandom_range(0, 3))
               0: f.strength = prev.strength;
               1: f.strength = prev.strength + 1'b1;
               2: f.strength = prev.strength - 1'b1;
               default: ;
            endcase
         end else begin
            f.point_x = COORD_PORT_BITS'($urandom_range(0, span_x - 1));
            f.point_y = COORD_PORT_BITS'($urandom_range(0, span_y - 1));
            if ($urandom_range(0, 7) == 0) begin
               f.strength = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end
         end
         if (pick < 20) begin
            op = OP_READ;
            if (locate_fine(f.point_x, f.point_y, fine_idx) && $urandom_range(0, 3) != 0) begin
               f.read_index = INDEX_PORT_BITS'(fine_idx);
            end
         end else if (pick < 30) begin
            op = OP_PROPAGATE;
         end else begin
            op = OP_OFFER;
            point_pool = {point_pool, f};
            if (point_pool.size() > 8) void'(point_pool.pop_front());
         end
      end
      send_request(op, f, 1'b0, '0);
   endtask

   initial begin : response_side
      int unsigned    stall;
      bit             quiet;
      rsp_fields_type got;
      rsp_tready = 1'b0;
      forever begin
         quiet = (responses_seen % 120) >= 90;
         stall = quiet ? 0 : $urandom_range(0, 14);
         if (responses_seen == PRESSURE_AT) stall = PRESSURE_HOLD;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = rsp_tdata[$bits(rsp_fields_type)-1:0];
         responses_seen++;
         if (pending_rsp_q.size() == 0) begin
            flag_failure("unexpected response", 0, rsp_tdata);
         end else begin
            check_response(pending_rsp_q.pop_front(), got);
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      probe_row_type probes [$];
      int            phase;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CLEAR;
      csr_valid  = 1'b0;
      csr_index  = REG_COARSE_WIDTH;
      csr_data   = '0;
      reset      = 1'b1;

      grid_reg[REG_COARSE_WIDTH]  = RST_COARSE_WIDTH;
      grid_reg[REG_COARSE_HEIGHT] = RST_COARSE_HEIGHT;
      grid_reg[REG_FINE_WIDTH]    = RST_FINE_WIDTH;
      grid_reg[REG_FINE_HEIGHT]   = RST_FINE_HEIGHT;
      grid_reg[REG_COARSE_COLS]   = RST_COARSE_COLS;
      grid_reg[REG_COARSE_COUNT]  = RST_COARSE_COUNT;
      grid_reg[REG_FINE_PER]      = RST_FINE_PER;
      grid_reg[REG_FINE_COLS]     = RST_FINE_COLS;
      cell_full = '0;
      cell_live = '1;

      // Directed requests under the reset grid: 64x64 coarse blocks of 4x4 fine cells.
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 1023, 1, 1, 1023, 0, 1, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 0, 0, 0, 0, 1, 1, 0, 1, 1, 1, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 0, 0, 0, 0, 1, 1, 0, 0, 1, 1, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 15, 15, 65535, 0, 1, 1, 0, 1, 1, 1, 15, 15, 65535)};
      probes = {probes, probe_row(OP_OFFER, 1, 1, 65534, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 511, 511, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 0, 512, 7, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 4095, 4095, 65535, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_PROPAGATE, 20, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 20, 0, 9, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_PROPAGATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 5, 5, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_PROPAGATE, 0, 4095, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_CLEAR, 4095, 4095, 65535, 1023, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 1, 1, 1, 1, 0, 1, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_OFFER, 63, 63, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
      probes = {probes, probe_row(OP_READ, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0)};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (probes[i]) begin
         send_request(probes[i].op, probes[i].fields, probes[i].typed, probes[i].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         await_idle();
         choose_grid(phase);
         load_grid();
         @(negedge clock);
         point_pool.delete();
         sender_quiet = (phase % 3 == 1);
         send_request(OP_CLEAR, '0, 1'b0, '0);
         repeat (ITEMS_PER_PHASE) issue_random_item();
      end

      await_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) flag_failure("responses missing", 0, pending_rsp_q.size());
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gbft_pkg.sv
hw/rtl/grid_best_feature_table_unit.sv
verif/testbench.sv
